// ===== rtl/core/per_key_byte_accounting_table_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-key byte accounting table
// Shared concurrent check forms, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_BYTE_ACCOUNTING_TABLE_DEFINES_SVH
`define PER_KEY_BYTE_ACCOUNTING_TABLE_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define PKBAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define PKBAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pkbat_pkg.sv =====
// ----------------------------------------------------------------------------
// pkbat_pkg
// Types and constants shared by the per-key byte accounting table modules.
// ----------------------------------------------------------------------------
package pkbat_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Field widths.
   localparam int KEY_W    = 32;
   localparam int AMT_W    = 33;
   localparam int TOTAL_W  = 64;
   localparam int KWORD_W  = KEY_W + 1;
   localparam int TWORD_W  = 2 * TOTAL_W;
   localparam int HALF_W   = 16;
   localparam int HASH_W   = HALF_W + CNT_W;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_SENT = 2'd0,
      OP_RECV = 2'd1,
      OP_READ = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_IGNORED  = 3'd2,
      ST_FULL     = 3'd3,
      ST_HIT      = 3'd4,
      ST_MISS     = 3'd5
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_CHECK
   } state_type;

   // Outcome of one probe, from the update logic to the sequencer.
   typedef struct packed {
      logic                done;
      logic                wr_key;
      logic                wr_tot;
      status_type          status;
      logic [TOTAL_W-1:0]  sent;
      logic [TOTAL_W-1:0]  recv;
   } upd_type;

endpackage

// ===== rtl/core/per_key_byte_accounting_table.sv =====
// ----------------------------------------------------------------------------
// per_key_byte_accounting_table
// Hashed table of process keys with 64-bit send and receive byte totals.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel carries an opcode (add sent bytes, add
// received bytes, read totals), a process key and a signed byte count. Each
// item gives exactly one rsp_ item with a status and the key's two totals.
// Keys sit in a key RAM and their totals in a totals RAM, both single-port
// with a registered read. A key is placed by hashing it to a home slot and
// probing linearly to the first free slot.
// Steps: the item is accepted in the idle state, then each probed slot takes
// a read step (S_LOOK) and a check step (S_CHECK). The result is loaded when
// the check resolves, and the next item can be taken once the sequencer is
// back in idle, so a key in its home slot needs a single probe. A miss on a
// full table probes every slot.
// Only one item is in work at a time; req_ready is high in the idle state.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when that item resolves, the check
// step holds without writing until the output register is free.
// Reset: a clearing pass writes every key RAM entry free, one per cycle, after
// reset falls; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
`include "per_key_byte_accounting_table_defines.svh"

module per_key_byte_accounting_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [pkbat_pkg::KEY_W-1:0]        req_process_id,
   input  logic signed [pkbat_pkg::AMT_W-1:0] req_amount,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [pkbat_pkg::TOTAL_W-1:0]      rsp_sent_total,
   output logic [pkbat_pkg::TOTAL_W-1:0]      rsp_received_total
);
   import pkbat_pkg::*;

   state_type                state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic signed [AMT_W-1:0]  amt_ff, amt_in;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic [IDX_W-1:0]         probes_ff, probes_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]       rsp_sent_ff, rsp_sent_in;
   logic [TOTAL_W-1:0]       rsp_recv_ff, rsp_recv_in;

   logic [HALF_W-1:0]        fold;
   logic [HASH_W-1:0]        hash_prod;
   logic [IDX_W-1:0]         home_slot;
   logic [IDX_W-1:0]         next_addr;
   logic                     last_probe;
   logic                     out_free;
   logic                     rsp_load;

   logic                     key_we, key_re, tot_we, tot_re;
   logic [IDX_W-1:0]         key_addr;
   logic [KWORD_W-1:0]       key_wdata, key_rdata;
   logic [TWORD_W-1:0]       tot_wdata, tot_rdata;

   upd_type                  upd;

   // Home slot: fold the key to 16 bits and scale it into the table range.
   always_comb begin
      fold      = req_process_id[HALF_W-1:0] ^ req_process_id[KEY_W-1:HALF_W];
      hash_prod = HASH_W'(fold) * HASH_W'(TABLE_ENTRIES);
      home_slot = hash_prod[HALF_W +: IDX_W];
   end

   // Probe chain bookkeeping.
   always_comb begin
      next_addr  = (addr_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : addr_ff + IDX_W'(1);
      last_probe = (probes_ff == IDX_W'(TABLE_ENTRIES - 1));
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Judge the probed slot.
   pkbat_update u_update (
      .op         (op_ff),
      .key        (key_ff),
      .amount     (amt_ff),
      .key_word   (key_rdata),
      .tot_word   (tot_rdata),
      .last_probe (last_probe),
      .upd        (upd)
   );

   // Sequencer: next state, RAM controls and result loading.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      addr_in       = addr_ff;
      probes_in     = probes_ff;
      clr_in        = clr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sent_in   = rsp_sent_ff;
      rsp_recv_in   = rsp_recv_ff;
      rsp_load      = 1'b0;
      req_ready     = 1'b0;
      key_we        = 1'b0;
      key_re        = 1'b0;
      tot_we        = 1'b0;
      tot_re        = 1'b0;
      key_addr      = addr_ff;
      key_wdata     = {1'b1, key_ff};
      tot_wdata     = {upd.sent, upd.recv};
      unique case (state_ff)
         S_CLEAR: begin
            key_we    = 1'b1;
            key_addr  = clr_ff;
            key_wdata = '0;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_opcode;
               key_in    = req_process_id;
               amt_in    = req_amount;
               addr_in   = home_slot;
               probes_in = '0;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            key_re   = 1'b1;
            tot_re   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (upd.done) begin
               if (out_free) begin
                  key_we        = upd.wr_key;
                  tot_we        = upd.wr_tot;
                  rsp_load      = 1'b1;
                  rsp_status_in = upd.status;
                  rsp_sent_in   = upd.sent;
                  rsp_recv_in   = upd.recv;
                  state_in      = S_IDLE;
               end
            end else begin
               addr_in   = next_addr;
               probes_in = probes_ff + IDX_W'(1);
               state_in  = S_LOOK;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      addr_ff       <= addr_in;
      probes_ff     <= probes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sent_ff   <= rsp_sent_in;
      rsp_recv_ff   <= rsp_recv_in;
   end

   // Key store: a valid flag above each 32-bit key.
   pkbat_ram #(
      .WIDTH (KWORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .re    (key_re),
      .addr  (key_addr),
      .wdata (key_wdata),
      .rdata (key_rdata)
   );

   // Totals store: send total above receive total.
   pkbat_ram #(
      .WIDTH (TWORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_tot_ram (
      .clock (clock),
      .we    (tot_we),
      .re    (tot_re),
      .addr  (addr_ff),
      .wdata (tot_wdata),
      .rdata (tot_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sent_total     = rsp_sent_ff;
   assign rsp_received_total = rsp_recv_ff;

   // Checks on the sequencer.
   `PKBAT_ASSERT_NOW(a_load_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready,
                     "result overwritten while still pending")
   `PKBAT_ASSERT_NOW(a_write_when, clock, reset, key_we || tot_we,
                     (state_ff == S_CLEAR) || rsp_load,
                     "RAM written outside clearing or result load")
   `PKBAT_ASSERT_NOW(a_probe_bound, clock, reset, (state_ff == S_CHECK) && last_probe,
                     upd.done, "probe chain ran past the table size")
   `PKBAT_ASSERT_NEXT(a_look_check, clock, reset, state_ff == S_LOOK, state_ff == S_CHECK,
                      "read not followed by a check")

endmodule

// ===== rtl/core/pkbat_ram.sv =====
// ----------------------------------------------------------------------------
// pkbat_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module pkbat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/pkbat_update.sv =====
// ----------------------------------------------------------------------------
// pkbat_update
// Judges one probed slot against the current item and forms the new totals.
// ----------------------------------------------------------------------------
module pkbat_update (
   input  logic [1:0]                     op,
   input  logic [pkbat_pkg::KEY_W-1:0]    key,
   input  logic signed [pkbat_pkg::AMT_W-1:0] amount,
   input  logic [pkbat_pkg::KWORD_W-1:0]  key_word,
   input  logic [pkbat_pkg::TWORD_W-1:0]  tot_word,
   input  logic                           last_probe,
   output pkbat_pkg::upd_type             upd
);
   import pkbat_pkg::*;

   logic               trivial;
   logic               recv_skip;
   logic               slot_used;
   logic               hit;
   logic [TOTAL_W-1:0] amt64;
   logic [TOTAL_W-1:0] cur_sent;
   logic [TOTAL_W-1:0] cur_recv;

   // Decode the item and the probed slot.
   always_comb begin
      trivial   = (key == '0) || !((op == OP_SENT) || (op == OP_RECV) || (op == OP_READ));
      recv_skip = (op == OP_RECV) && (amount[AMT_W-1] || (amount == '0));
      slot_used = key_word[KWORD_W-1];
      hit       = slot_used && (key_word[KEY_W-1:0] == key);
      amt64     = {{(TOTAL_W-AMT_W){amount[AMT_W-1]}}, amount};
      cur_sent  = tot_word[TWORD_W-1:TOTAL_W];
      cur_recv  = tot_word[TOTAL_W-1:0];
   end

   // Outcome of the probe: resolve now, or move to the next slot.
   always_comb begin
      upd        = '0;
      upd.status = ST_IGNORED;
      if (trivial) begin
         upd.done = 1'b1;
      end else if (hit) begin
         upd.done = 1'b1;
         upd.sent = cur_sent;
         upd.recv = cur_recv;
         if (op == OP_READ) begin
            upd.status = ST_HIT;
         end else if (!recv_skip) begin
            upd.status = ST_UPDATED;
            upd.wr_tot = 1'b1;
            if (op == OP_SENT) begin
               upd.sent = cur_sent + amt64;
            end else begin
               upd.recv = cur_recv + amt64;
            end
         end
      end else if (!slot_used || last_probe) begin
         // The key is absent: a free slot ends the chain, or every slot was seen.
         upd.done = 1'b1;
         if (op == OP_READ) begin
            upd.status = ST_MISS;
         end else if (recv_skip) begin
            upd.status = ST_IGNORED;
         end else if (!slot_used) begin
            upd.status = ST_INSERTED;
            upd.wr_key = 1'b1;
            upd.wr_tot = 1'b1;
            upd.sent   = (op == OP_SENT) ? amt64 : '0;
            upd.recv   = (op == OP_RECV) ? amt64 : '0;
         end else begin
            upd.status = ST_FULL;
         end
      end
   end

endmodule
